// ----- rtl/gps_fix_to_local_offset_top_macros.svh -----
// Assertion macros shared by the checker of the GPS fix to local offset block.
`ifndef GPS_FIX_TO_LOCAL_OFFSET_TOP_MACROS_SVH
`define GPS_FIX_TO_LOCAL_OFFSET_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gfo_pkg.sv -----
// Shared constants, types and the arctangent table of the GPS fix to local offset block.
package gfo_pkg;

    // Q30 angle and unit constants.
    localparam logic [30:0] HALF_PI_Q  = 31'd1686629713;
    localparam logic [31:0] PI_Q       = 32'd3373259426;
    localparam logic [32:0] TWO_PI_Q   = 33'd6746518852;
    localparam logic [29:0] GAIN_INV_Q = 30'd652032874;
    localparam logic [30:0] Q_ONE      = 31'd1073741824;

    // Twice the sphere radius in centimetres, and the saturation value of a distance.
    localparam logic [30:0] DIAM_CM  = 31'd1274200000;
    localparam logic [30:0] DIST_MAX = 31'd2001600000;

    typedef logic signed [31:0] trig_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sq_t;

    typedef enum logic {
        CFG_ORIGIN_LAT = 1'b0,
        CFG_ORIGIN_LON = 1'b1
    } cfg_idx_t;

    // atan(2^-i) in Q30.
    function automatic logic [29:0] atan_q(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            5'd31: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/gfo_sincos.sv -----
// Pipelined degree-to-radian scaling, angle folding and rotation CORDIC sine and cosine.
module gfo_sincos #(
    parameter int CORDIC_STEPS = 24,
    parameter bit HALF_MODE    = 1'b0
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [33:0]  ang_in,
    output gfo_pkg::trig_t      sin_q,
    output gfo_pkg::trig_t      cos_q
);

    // Half angles take the magnitude and divide by twice the divisor.
    localparam logic [30:0] DIV     = HALF_MODE ? 31'd1800000000 : 31'd900000000;
    localparam logic [95:0] K_WIDE  = (96'(gfo_pkg::HALF_PI_Q) << 34) / 96'(DIV);
    localparam logic [35:0] K_RECIP = K_WIDE[35:0];
    localparam logic signed [35:0] PI_S      = 36'(gfo_pkg::PI_Q);
    localparam logic signed [35:0] TWO_PI_S  = 36'(gfo_pkg::TWO_PI_Q);
    localparam logic signed [35:0] HALF_PI_S = 36'(gfo_pkg::HALF_PI_Q);

    logic [33:0] mag;
    logic [69:0] kprod;
    logic [63:0] sa_p_reg;
    logic [33:0] sa_q_reg;
    logic        sa_neg_reg;
    logic [63:0] sb_p_reg;
    logic [33:0] sb_q_reg;
    logic [64:0] sb_qd_reg;
    logic        sb_neg_reg;
    logic [64:0] rem;
    logic [33:0] qf;
    logic signed [35:0] sc_ang_reg;
    logic signed [35:0] sc_ang_next;
    logic signed [35:0] sd_ang_reg;
    logic signed [35:0] sd_ang_next;
    logic signed [35:0] fold_ang;
    logic               fold_neg;

    logic signed [33:0] x_reg [0:CORDIC_STEPS];
    logic signed [33:0] y_reg [0:CORDIC_STEPS];
    logic signed [35:0] z_reg [0:CORDIC_STEPS];
    logic               ng_reg [0:CORDIC_STEPS];
    gfo_pkg::trig_t     sin_reg;
    gfo_pkg::trig_t     cos_reg;

    // Scaling: an estimate from the reciprocal, then one exact correction.
    always_comb
    begin
        mag   = ang_in[33] ? 34'(-ang_in) : 34'(ang_in);
        kprod = 70'(mag) * 70'(K_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_p_reg   <= 64'(mag) * 64'(gfo_pkg::HALF_PI_Q);
            sa_q_reg   <= kprod[67:34];
            sa_neg_reg <= !HALF_MODE && ang_in[33];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_p_reg   <= sa_p_reg;
            sb_q_reg   <= sa_q_reg;
            sb_qd_reg  <= 65'(sa_q_reg) * 65'(DIV);
            sb_neg_reg <= sa_neg_reg;
        end
    end

    always_comb
    begin
        rem         = 65'(sb_p_reg) - sb_qd_reg;
        qf          = sb_q_reg + 34'(rem >= 65'(DIV));
        sc_ang_next = sb_neg_reg ? -$signed(36'(qf)) : $signed(36'(qf));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_ang_reg <= sc_ang_next;
        end
    end

    // Wrap into [-pi, pi].
    always_comb
    begin
        priority if (sc_ang_reg > PI_S)
        begin
            sd_ang_next = sc_ang_reg - TWO_PI_S;
        end
        else if (sc_ang_reg < -PI_S)
        begin
            sd_ang_next = sc_ang_reg + TWO_PI_S;
        end
        else
        begin
            sd_ang_next = sc_ang_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_ang_reg <= sd_ang_next;
        end
    end

    // Fold into [-pi/2, pi/2]; the folded half negates both results.
    always_comb
    begin
        priority if (sd_ang_reg > HALF_PI_S)
        begin
            fold_ang = sd_ang_reg - PI_S;
            fold_neg = 1'b1;
        end
        else if (sd_ang_reg < -HALF_PI_S)
        begin
            fold_ang = sd_ang_reg + PI_S;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_ang = sd_ang_reg;
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= $signed(34'(gfo_pkg::GAIN_INV_Q));
            y_reg[0]  <= '0;
            z_reg[0]  <= fold_ang;
            ng_reg[0] <= fold_neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [35:0] at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = $signed(36'(gfo_pkg::atan_q(5'(i))));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i + 1] <= x_reg[i] - dx;
                    y_reg[i + 1] <= y_reg[i] + dy;
                    z_reg[i + 1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i + 1] <= x_reg[i] + dx;
                    y_reg[i + 1] <= y_reg[i] - dy;
                    z_reg[i + 1] <= z_reg[i] + at;
                end
                ng_reg[i + 1] <= ng_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= ng_reg[CORDIC_STEPS] ? 32'(-y_reg[CORDIC_STEPS])
                                            : 32'(y_reg[CORDIC_STEPS]);
            cos_reg <= ng_reg[CORDIC_STEPS] ? 32'(-x_reg[CORDIC_STEPS])
                                            : 32'(x_reg[CORDIC_STEPS]);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ----- rtl/gfo_dist.sv -----
// Pipelined square roots, vectoring CORDIC arctangent and scaling to a distance in centimetres.
module gfo_dist #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] a_q,
    output logic [30:0] dist_cm
);

    function automatic gfo_pkg::sq_t sq_step(input gfo_pkg::sq_t cur, input logic [63:0] bitv);
        gfo_pkg::sq_t nx;
        logic [63:0]  trial;
        trial = cur.res + bitv;
        if (cur.n >= trial)
        begin
            nx.n   = cur.n - trial;
            nx.res = (cur.res >> 1) + bitv;
        end
        else
        begin
            nx.n   = cur.n;
            nx.res = cur.res >> 1;
        end
        return nx;
    endfunction

    gfo_pkg::sq_t s_reg [0:31];
    gfo_pkg::sq_t c_reg [0:31];
    gfo_pkg::sq_t s_init;
    gfo_pkg::sq_t c_init;

    logic signed [35:0] ax_reg [0:CORDIC_STEPS-1];
    logic signed [35:0] ay_reg [0:CORDIC_STEPS-1];
    logic signed [32:0] az_reg [0:CORDIC_STEPS-1];
    logic               zf_reg [0:CORDIC_STEPS-1];
    logic signed [35:0] x_init;
    logic signed [35:0] y_init;
    logic               zf_init;

    logic [30:0] zc;
    logic [61:0] prod_reg;
    logic [62:0] rounded;
    logic [30:0] dist_reg;
    logic [30:0] dist_next;

    always_comb
    begin
        s_init.n   = {3'b0, a_q, 30'b0};
        s_init.res = '0;
        c_init.n   = {3'b0, 31'(gfo_pkg::Q_ONE - a_q), 30'b0};
        c_init.res = '0;
    end

    // One result bit per stage for both roots.
    for (genvar k = 0; k < 32; k++)
    begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        gfo_pkg::sq_t s_cur;
        gfo_pkg::sq_t c_cur;

        if (k == 0)
        begin : g_first
            assign s_cur = s_init;
            assign c_cur = c_init;
        end
        else
        begin : g_next
            assign s_cur = s_reg[k - 1];
            assign c_cur = c_reg[k - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k] <= sq_step(s_cur, BITV);
                c_reg[k] <= sq_step(c_cur, BITV);
            end
        end
    end

    always_comb
    begin
        y_init  = $signed({4'b0, s_reg[31].res[31:0]});
        x_init  = $signed({4'b0, c_reg[31].res[31:0]});
        zf_init = (s_reg[31].res == '0) && (c_reg[31].res == '0);
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_vec
        logic signed [35:0] cx;
        logic signed [35:0] cy;
        logic signed [32:0] cz;
        logic               cf;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        logic signed [32:0] at;

        if (j == 0)
        begin : g_first
            assign cx = x_init;
            assign cy = y_init;
            assign cz = '0;
            assign cf = zf_init;
        end
        else
        begin : g_next
            assign cx = ax_reg[j - 1];
            assign cy = ay_reg[j - 1];
            assign cz = az_reg[j - 1];
            assign cf = zf_reg[j - 1];
        end

        assign dx = cy >>> j;
        assign dy = cx >>> j;
        assign at = $signed(33'(gfo_pkg::atan_q(5'(j))));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy > 0)
                begin
                    ax_reg[j] <= cx + dx;
                    ay_reg[j] <= cy - dy;
                    az_reg[j] <= cz + at;
                end
                else
                begin
                    ax_reg[j] <= cx - dx;
                    ay_reg[j] <= cy + dy;
                    az_reg[j] <= cz - at;
                end
                zf_reg[j] <= cf;
            end
        end
    end

    // A zero vector and a slightly negative angle both give zero distance.
    always_comb
    begin
        if (zf_reg[CORDIC_STEPS-1] || az_reg[CORDIC_STEPS-1] < 0)
        begin
            zc = '0;
        end
        else
        begin
            zc = az_reg[CORDIC_STEPS-1][30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 62'(zc) * 62'(gfo_pkg::DIAM_CM);
        end
    end

    always_comb
    begin
        rounded   = 63'(prod_reg) + (63'd1 << 29);
        dist_next = (rounded[62:30] > 33'(gfo_pkg::DIST_MAX)) ? gfo_pkg::DIST_MAX
                                                               : rounded[60:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_cm = dist_reg;

endmodule

// ----- rtl/gps_fix_to_local_offset_top.sv -----
// Top level of the GPS fix to local offset block: conversion, trig lanes and distance lanes.
//
//  Channel  | Handshake               | Word
//  ---------+-------------------------+-----------------------------------------------
//  input    | in_valid / in_stall     | lat_raw, is_north, lon_raw, is_west
//  output   | out_valid / out_stall   | lat_deg, lon_deg, north_dist_cm, east_dist_cm
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One word is taken every cycle unless a held output word freezes the pipeline.
// The depth is set by the two CORDIC chains (one stage per iteration) and the
// 32-stage root chain, with short conversion and multiply sections around them.
// Reset clears the origin registers and the valid bits of every stage.
// While an output word is held by out_stall the whole pipeline freezes, so
// in_stall follows it in the same cycle and nothing is lost or repeated.
module gps_fix_to_local_offset_top #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [26:0]        lat_raw,
    input  logic               is_north,
    input  logic [27:0]        lon_raw,
    input  logic               is_west,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [30:0] lat_deg,
    output logic signed [31:0] lon_deg,
    output logic [30:0]        north_dist_cm,
    output logic [30:0]        east_dist_cm,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    // Stage counts: four conversion stages, one difference stage, the trig lanes,
    // four multiply stages and the distance lanes.
    localparam int L_SC    = CORDIC_STEPS + 6;
    localparam int L_DIST  = CORDIC_STEPS + 34;
    localparam int TOTAL   = 9 + L_SC + L_DIST;
    localparam int LL_LEN  = TOTAL - 4;

    localparam logic [33:0] LAT_LIM = 34'd1073741823;
    localparam logic [33:0] LON_LIM = 34'd2147483647;

    // Product of two Q30 values, rounded towards minus infinity.
    function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] pr;
        pr = 66'(a) * 66'(b);
        return pr[62:30];
    endfunction

    logic en;
    logic vld_reg [0:TOTAL-1];

    logic signed [30:0] origin_lat_reg;
    logic signed [31:0] origin_lon_reg;

    // Conversion stages; element 0 is latitude, element 1 longitude.
    logic [27:0] raw_in   [0:1];
    logic [8:0]  qe_in    [0:1];
    logic [27:0] c1_raw_reg [0:1];
    logic [8:0]  c1_qe_reg  [0:1];
    logic        c1_neg_reg [0:1];
    logic [8:0]  c2_deg_next [0:1];
    logic [19:0] c2_min_next [0:1];
    logic [8:0]  c2_deg_reg [0:1];
    logic [19:0] c2_min_reg [0:1];
    logic        c2_neg_reg [0:1];
    logic [33:0] c3_deg7_reg [0:1];
    logic [24:0] c3_frac_reg [0:1];
    logic        c3_neg_reg  [0:1];
    logic [24:0] frac_next   [0:1];
    logic [33:0] v_sum   [0:1];
    logic signed [30:0] s4_lat_reg;
    logic signed [31:0] s4_lon_reg;
    logic signed [30:0] s4_lat_next;
    logic signed [31:0] s4_lon_next;

    logic signed [33:0] s5_dlat_reg;
    logic signed [33:0] s5_dlon_reg;
    logic signed [33:0] s5_olat_reg;
    logic signed [33:0] s5_lat_reg;

    gfo_pkg::trig_t sin_dlat, cos_dlat;
    gfo_pkg::trig_t sin_dlon, cos_dlon;
    gfo_pkg::trig_t sin_olat, cos_olat;
    gfo_pkg::trig_t sin_lat,  cos_lat;
    gfo_pkg::trig_t sin_zero, cos_zero;

    logic signed [32:0] m1_n1_reg, m1_z_reg, m1_e2_reg, m1_cb_reg, m1_cc_reg;
    logic signed [32:0] m2_n1_reg, m2_z_reg, m2_n3_reg, m2_e3_reg, m2_cb_reg, m2_cc_reg;
    logic signed [32:0] m3_n1_reg, m3_z_reg, m3_n4_reg, m3_e4_reg;
    logic signed [33:0] a_north_sum, a_east_sum;
    logic [30:0]        m4_an_reg, m4_ae_reg;
    logic [30:0]        an_next, ae_next;

    logic signed [30:0] ll_lat_reg [0:LL_LEN-1];
    logic signed [31:0] ll_lon_reg [0:LL_LEN-1];

    // The pipeline moves unless the output word is waiting on a stall.
    assign en        = !(vld_reg[TOTAL-1] && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_lat_reg <= '0;
            origin_lon_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gfo_pkg::cfg_idx_t'(cfg_index))
                gfo_pkg::CFG_ORIGIN_LAT: origin_lat_reg <= cfg_data[30:0];
                gfo_pkg::CFG_ORIGIN_LON: origin_lon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits, one per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOTAL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < TOTAL; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    // Stage 1: estimate the whole degrees with a reciprocal of one million,
    // which is at most one short.
    always_comb
    begin
        raw_in[0] = 28'(lat_raw);
        raw_in[1] = lon_raw;
        for (int k = 0; k < 2; k++)
        begin
            qe_in[k] = 9'((41'(raw_in[k]) * 41'd4294) >> 32);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                c1_raw_reg[k] <= raw_in[k];
                c1_qe_reg[k]  <= qe_in[k];
            end
            c1_neg_reg[0] <= !is_north;
            c1_neg_reg[1] <= is_west;
        end
    end

    // Stage 2: remainder in ten-thousandths of a minute, with the correction.
    always_comb
    begin
        logic [28:0] r;
        for (int k = 0; k < 2; k++)
        begin
            r = 29'(c1_raw_reg[k]) - 29'(c1_qe_reg[k]) * 29'd1000000;
            if (r >= 29'd1000000)
            begin
                c2_deg_next[k] = c1_qe_reg[k] + 9'd1;
                c2_min_next[k] = 20'(r - 29'd1000000);
            end
            else
            begin
                c2_deg_next[k] = c1_qe_reg[k];
                c2_min_next[k] = 20'(r);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                c2_deg_reg[k] <= c2_deg_next[k];
                c2_min_reg[k] <= c2_min_next[k];
                c2_neg_reg[k] <= c1_neg_reg[k];
            end
        end
    end

    // Stage 3: degrees times 10^7, and minutes/60 rounded half up as (50m + 1)/3.
    // The division by three is a multiplication by its reciprocal scaled by 2^33.
    always_comb
    begin
        logic [25:0] t;
        logic [57:0] p;
        for (int k = 0; k < 2; k++)
        begin
            t            = 26'(c2_min_reg[k]) * 26'd50 + 26'd1;
            p            = 58'(t) * 58'h0AAAAAAAB;
            frac_next[k] = p[57:33];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                c3_deg7_reg[k] <= 34'(c2_deg_reg[k]) * 34'd10000000;
                c3_frac_reg[k] <= frac_next[k];
                c3_neg_reg[k]  <= c2_neg_reg[k];
            end
        end
    end

    // Stage 4: sum, clamp to the field and apply the hemisphere.
    always_comb
    begin
        logic [33:0] lat_c;
        logic [33:0] lon_c;
        for (int k = 0; k < 2; k++)
        begin
            v_sum[k] = c3_deg7_reg[k] + 34'(c3_frac_reg[k]);
        end
        lat_c       = (v_sum[0] > LAT_LIM) ? LAT_LIM : v_sum[0];
        lon_c       = (v_sum[1] > LON_LIM) ? LON_LIM : v_sum[1];
        s4_lat_next = c3_neg_reg[0] ? -$signed(lat_c[30:0]) : $signed(lat_c[30:0]);
        s4_lon_next = c3_neg_reg[1] ? -$signed(lon_c[31:0]) : $signed(lon_c[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_lat_reg <= s4_lat_next;
            s4_lon_reg <= s4_lon_next;
        end
    end

    // Stage 5: angle differences against the origin.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_dlat_reg <= 34'(s4_lat_reg) - 34'(origin_lat_reg);
            s5_dlon_reg <= 34'(s4_lon_reg) - 34'(origin_lon_reg);
            s5_olat_reg <= 34'(origin_lat_reg);
            s5_lat_reg  <= 34'(s4_lat_reg);
        end
    end

    // Five trig lanes: the half latitude difference, the half longitude
    // difference, both latitudes, and the half angle of a zero difference.
    gfo_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .HALF_MODE(1'b1)) u_sc_dlat (
        .clk(clk), .en(en), .ang_in(s5_dlat_reg), .sin_q(sin_dlat), .cos_q(cos_dlat)
    );

    gfo_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .HALF_MODE(1'b1)) u_sc_dlon (
        .clk(clk), .en(en), .ang_in(s5_dlon_reg), .sin_q(sin_dlon), .cos_q(cos_dlon)
    );

    gfo_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .HALF_MODE(1'b0)) u_sc_olat (
        .clk(clk), .en(en), .ang_in(s5_olat_reg), .sin_q(sin_olat), .cos_q(cos_olat)
    );

    gfo_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .HALF_MODE(1'b0)) u_sc_lat (
        .clk(clk), .en(en), .ang_in(s5_lat_reg), .sin_q(sin_lat), .cos_q(cos_lat)
    );

    gfo_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .HALF_MODE(1'b1)) u_sc_zero (
        .clk(clk), .en(en), .ang_in(34'sd0), .sin_q(sin_zero), .cos_q(cos_zero)
    );

    // Haversine terms, one multiplication per term and stage, then the clamped sums. North
    // uses the half latitude difference and a zero longitude difference; east the reverse.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_n1_reg <= mulq(33'(sin_dlat), 33'(sin_dlat));
            m1_z_reg  <= mulq(33'(sin_zero), 33'(sin_zero));
            m1_e2_reg <= mulq(33'(sin_dlon), 33'(sin_dlon));
            m1_cb_reg <= 33'(cos_olat);
            m1_cc_reg <= 33'(cos_lat);

            m2_n1_reg <= m1_n1_reg;
            m2_z_reg  <= m1_z_reg;
            m2_n3_reg <= mulq(m1_z_reg, m1_cb_reg);
            m2_e3_reg <= mulq(m1_e2_reg, m1_cb_reg);
            m2_cb_reg <= m1_cb_reg;
            m2_cc_reg <= m1_cc_reg;

            m3_n1_reg <= m2_n1_reg;
            m3_z_reg  <= m2_z_reg;
            m3_n4_reg <= mulq(m2_n3_reg, m2_cc_reg);
            m3_e4_reg <= mulq(m2_e3_reg, m2_cb_reg);

            m4_an_reg <= an_next;
            m4_ae_reg <= ae_next;
        end
    end

    // The haversine term is held to [0, 1].
    always_comb
    begin
        a_north_sum = 34'(m3_n1_reg) + 34'(m3_n4_reg);
        a_east_sum  = 34'(m3_z_reg) + 34'(m3_e4_reg);
        if (a_north_sum < 0)
        begin
            an_next = '0;
        end
        else if (a_north_sum > $signed(34'(gfo_pkg::Q_ONE)))
        begin
            an_next = gfo_pkg::Q_ONE;
        end
        else
        begin
            an_next = a_north_sum[30:0];
        end
        if (a_east_sum < 0)
        begin
            ae_next = '0;
        end
        else if (a_east_sum > $signed(34'(gfo_pkg::Q_ONE)))
        begin
            ae_next = gfo_pkg::Q_ONE;
        end
        else
        begin
            ae_next = a_east_sum[30:0];
        end
    end

    gfo_dist #(.CORDIC_STEPS(CORDIC_STEPS)) u_dist_north (
        .clk(clk), .en(en), .a_q(m4_an_reg), .dist_cm(north_dist_cm)
    );

    gfo_dist #(.CORDIC_STEPS(CORDIC_STEPS)) u_dist_east (
        .clk(clk), .en(en), .a_q(m4_ae_reg), .dist_cm(east_dist_cm)
    );

    // The converted fix travels alongside the distance lanes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_lat_reg[0] <= s4_lat_reg;
            ll_lon_reg[0] <= s4_lon_reg;
            for (int k = 1; k < LL_LEN; k++)
            begin
                ll_lat_reg[k] <= ll_lat_reg[k - 1];
                ll_lon_reg[k] <= ll_lon_reg[k - 1];
            end
        end
    end

    assign out_valid = vld_reg[TOTAL-1];
    assign lat_deg   = ll_lat_reg[LL_LEN-1];
    assign lon_deg   = ll_lon_reg[LL_LEN-1];

endmodule

// ----- rtl/gfo_chk.sv -----
// Port checker of the GPS fix to local offset block and its binding to the top level.
`include "gps_fix_to_local_offset_top_macros.svh"

module gfo_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [26:0]        lat_raw,
    input logic               is_north,
    input logic [27:0]        lon_raw,
    input logic               is_west,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [30:0] lat_deg,
    input logic signed [31:0] lon_deg,
    input logic [30:0]        north_dist_cm,
    input logic [30:0]        east_dist_cm,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               cfg_index,
    input logic [31:0]        cfg_data
);

    // A held output word keeps its distances and latitude until it is taken.
    `GFO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(north_dist_cm) && $stable(east_dist_cm) && $stable(lat_deg), "output word changed while stalled")

    // The input side only stalls when an output word is being held back.
    `GFO_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without an output stall")

    // Distances never exceed the saturation value.
    `GFO_ASSERT_NOW(a_dist_sat, out_valid, (north_dist_cm <= 31'd2001600000) && (east_dist_cm <= 31'd2001600000), "distance above saturation value")

    // The latitude clamp never yields the most negative code.
    `GFO_ASSERT_NOW(a_lat_clamp, out_valid, lat_deg != -31'sd1073741824, "latitude outside clamp range")

endmodule

bind gps_fix_to_local_offset_top gfo_chk u_gfo_chk (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the GPS fix to local offset block.

// Expected words of the block, worked out from the accepted fixes and the origin registers.
class fix_offset_board;
    typedef struct {
        logic [30:0] lat;
        logic [31:0] lon;
        logic [30:0] north;
        logic [30:0] east;
    } offset_word_t;

    localparam longint ONE_Q     = 64'd1073741824;
    localparam longint HALF_PI   = 64'd1686629713;
    localparam longint PI        = 64'd3373259426;
    localparam longint TWO_PI    = 64'd6746518852;
    localparam longint GAIN_INV  = 64'd652032874;
    localparam longint RADIUS_CM = 64'd637100000;
    localparam longint DIST_TOP  = 64'd2001600000;
    localparam int     STEPS     = 24;

    longint       arctan [32];
    longint       org_lat;
    longint       org_lon;
    offset_word_t awaited[$];
    int           errors;
    int           checked;

    function new();
        arctan = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                   64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                   64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                   64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                   64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                   64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
                   64'h00000001, 64'h00000000};
        org_lat = 0;
        org_lon = 0;
        errors  = 0;
        checked = 0;
    endfunction

    function void set_origin(gfo_pkg::cfg_idx_t idx, logic [31:0] data);
        if (idx == gfo_pkg::CFG_ORIGIN_LAT)
            org_lat = longint'($signed(data[30:0]));
        else
            org_lon = longint'($signed(data));
    endfunction

    function longint mul_q(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function void sin_cos(longint ang, output longint s, output longint c);
        longint r, x, y, dx, dy;
        bit     flip;
        r = ang % TWO_PI;
        x = GAIN_INV;
        y = 0;
        flip = 0;
        if (r > PI) r -= TWO_PI;
        if (r < -PI) r += TWO_PI;
        if (r > HALF_PI) begin r -= PI; flip = 1; end
        else if (r < -HALF_PI) begin r += PI; flip = 1; end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin x -= dx; y += dy; r -= arctan[i]; end
            else begin x += dx; y -= dy; r += arctan[i]; end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function longint arctan2(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin x += dx; y -= dy; z += arctan[i]; end
            else begin x -= dx; y += dy; z -= arctan[i]; end
        end
        return z;
    endfunction

    function longint root_q(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + b) begin n -= res + b; res = (res >> 1) + b; end
            else res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function longint great_circle_cm(longint lat1, longint lat2, longint dlon);
        longint s1, c1, s2, c2, sl, cl, sn, cn, a, z, hl, hn;
        hl = lat2 - lat1;
        if (hl < 0) hl = -hl;
        hn = dlon < 0 ? -dlon : dlon;
        sin_cos(hl * HALF_PI / 1800000000, sl, cl);
        sin_cos(hn * HALF_PI / 1800000000, sn, cn);
        sin_cos(lat1 * HALF_PI / 900000000, s1, c1);
        sin_cos(lat2 * HALF_PI / 900000000, s2, c2);
        a = mul_q(sl, sl) + mul_q(mul_q(mul_q(sn, sn), c1), c2);
        if (a < 0) a = 0;
        if (a > ONE_Q) a = ONE_Q;
        z = arctan2(root_q(longint'(a) << 30), root_q(longint'(ONE_Q - a) << 30));
        if (z < 0) z = 0;
        z = (2 * RADIUS_CM * z + (64'd1 << 29)) >>> 30;
        if (z > DIST_TOP) z = DIST_TOP;
        return z;
    endfunction

    function longint nmea_to_deg(longint raw, bit negate, longint lim);
        longint d, m, v;
        d = raw / 1000000;
        m = raw % 1000000;
        v = d * 10000000 + (50 * m + 1) / 3;
        if (v > lim) v = lim;
        return negate ? -v : v;
    endfunction

    function void note_fix(logic [26:0] lat_raw, logic is_north, logic [27:0] lon_raw,
                           logic is_west);
        offset_word_t w;
        longint       lat, lon, n, e;
        lat = nmea_to_deg(longint'(lat_raw), !is_north, (64'd1 << 30) - 1);
        lon = nmea_to_deg(longint'(lon_raw), is_west, (64'd1 << 31) - 1);
        n = great_circle_cm(org_lat, lat, 0);
        e = great_circle_cm(org_lat, org_lat, lon - org_lon);
        w.lat   = lat[30:0];
        w.lon   = lon[31:0];
        w.north = n[30:0];
        w.east  = e[30:0];
        awaited.push_back(w);
    endfunction

    function void check_word(logic [30:0] lat, logic [31:0] lon, logic [30:0] north,
                             logic [30:0] east);
        offset_word_t w;
        if (awaited.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual lat %0d lon %0d",
                     $time, $signed(lat), $signed(lon));
            errors++;
            return;
        end
        w = awaited.pop_front();
        checked++;
        if (lat !== w.lat)
        begin
            $display("%0t: lat_deg expected %0d actual %0d", $time, $signed(w.lat),
                     $signed(lat));
            errors++;
        end
        if (lon !== w.lon)
        begin
            $display("%0t: lon_deg expected %0d actual %0d", $time, $signed(w.lon),
                     $signed(lon));
            errors++;
        end
        if (north !== w.north)
        begin
            $display("%0t: north_dist_cm expected %0d actual %0d", $time, w.north, north);
            errors++;
        end
        if (east !== w.east)
        begin
            $display("%0t: east_dist_cm expected %0d actual %0d", $time, w.east, east);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [26:0]        lat_raw;
    logic               is_north;
    logic [27:0]        lon_raw;
    logic               is_west;
    logic               out_valid;
    logic               out_stall;
    logic signed [30:0] lat_deg;
    logic signed [31:0] lon_deg;
    logic [30:0]        north_dist_cm;
    logic [30:0]        east_dist_cm;
    logic               cfg_valid;
    logic               cfg_ready;
    gfo_pkg::cfg_idx_t  cfg_index;
    logic [31:0]        cfg_data;

    // Settling waits cover the pipeline depth and allow a little more.
    localparam int PIPE_DEPTH = 2 * 24 + 49;
    localparam int SETTLE     = PIPE_DEPTH + 20;

    fix_offset_board board = new();
    bit  calm;        // set for the last part of the run: no idling on either side
    int  stall_left;
    int  fixes_sent;
    int  origins_set;

    gps_fix_to_local_offset_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .lat_raw       (lat_raw),
        .is_north      (is_north),
        .lon_raw       (lon_raw),
        .is_west       (is_west),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lat_deg       (lat_deg),
        .lon_deg       (lon_deg),
        .north_dist_cm (north_dist_cm),
        .east_dist_cm  (east_dist_cm),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver back-pressure: stall bursts of random length separated by free stretches
    // of random length, so stalls land on every phase of the output stream.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        else if (!calm && !out_stall && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 6);
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left = calm ? 0 : $urandom_range(0, 12);
        end
    end

    // Output monitor. Values read here are those sampled before this edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(lat_deg, lon_deg, north_dist_cm, east_dist_cm);
    end

    // Offers one fix and holds it until the block takes it. The caller decides whether
    // valid drops afterwards, so valid is never lowered and raised in the same step.
    task automatic offer_fix(logic [26:0] lat, logic n, logic [27:0] lon, logic w);
        in_valid <= 1'b1;
        lat_raw  <= lat;
        is_north <= n;
        lon_raw  <= lon;
        is_west  <= w;
        do
            @(posedge clk);
        while (in_stall);
        board.note_fix(lat, n, lon, w);
        fixes_sent++;
    endtask

    // Sender idling: now and then valid drops for a burst of random length.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Waits for every awaited word, then for the pipeline to run empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_origin(gfo_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_origin(idx, data);
        origins_set++;
    endtask

    task automatic set_origins(int lat, int lon);
        write_origin(gfo_pkg::CFG_ORIGIN_LAT, 32'(lat));
        write_origin(gfo_pkg::CFG_ORIGIN_LON, 32'(lon));
    endtask

    // A random fix. Most are well-formed NMEA words; some lie below three degrees of latitude and
    // longitude, so that short distances are exercised, and a few carry arbitrary bits, minutes of
    // 60 and above included.
    task automatic random_fix();
        logic [26:0] lat;
        logic [27:0] lon;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            lat = 27'($urandom);
            lon = 28'($urandom);
        end
        else if (pick <= 2)
        begin
            lat = 27'($urandom_range(0, 2) * 1000000 + $urandom_range(0, 599999));
            lon = 28'($urandom_range(0, 2) * 1000000 + $urandom_range(0, 599999));
        end
        else
        begin
            lat = 27'($urandom_range(0, 89) * 1000000 + $urandom_range(0, 599999));
            lon = 28'($urandom_range(0, 179) * 1000000 + $urandom_range(0, 599999));
        end
        offer_fix(lat, 1'($urandom), lon, 1'($urandom));
        sender_gap();
    endtask

    task automatic random_phase(int count);
        repeat (count) random_fix();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        lat_raw     = '0;
        is_north    = 1'b0;
        lon_raw     = '0;
        is_west     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = gfo_pkg::CFG_ORIGIN_LAT;
        cfg_data    = '0;
        calm        = 1'b0;
        fixes_sent  = 0;
        origins_set = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed fixes at the reset origin: zero, poles, the date line, both hemispheres,
        // half-up rounding of minutes, minutes of 60 and beyond, and raw words so large
        // that the converted value clamps.
        offer_fix(27'd0, 1'b1, 28'd0, 1'b0);
        offer_fix(27'd0, 1'b0, 28'd0, 1'b1);
        offer_fix(27'd90000000, 1'b1, 28'd180000000, 1'b0);
        offer_fix(27'd90000000, 1'b0, 28'd180000000, 1'b1);
        offer_fix(27'd45300000, 1'b1, 28'd120300000, 1'b1);
        offer_fix(27'd1, 1'b1, 28'd1, 1'b0);
        offer_fix(27'd2, 1'b0, 28'd2, 1'b1);
        offer_fix(27'd999999, 1'b1, 28'd999999, 1'b0);
        offer_fix(27'd59999999, 1'b0, 28'd179999999, 1'b1);
        offer_fix(27'h7FFFFFF, 1'b1, 28'hFFFFFFF, 1'b0);
        offer_fix(27'h7FFFFFF, 1'b0, 28'hFFFFFFF, 1'b1);
        offer_fix(27'd107374182, 1'b1, 28'd214748364, 1'b1);
        offer_fix(27'd0, 1'b1, 28'd90000000, 1'b0);
        offer_fix(27'd0, 1'b1, 28'd90000000, 1'b1);

        // The sender holds off here until every word has come back.
        drain();
        random_phase(300);
        drain();

        // Extreme origins: the north-east corner, then the south-west corner.
        set_origins(900000000, 1800000000);
        offer_fix(27'd90000000, 1'b1, 28'd180000000, 1'b0);
        offer_fix(27'd90000000, 1'b0, 28'd180000000, 1'b1);
        offer_fix(27'd0, 1'b1, 28'd0, 1'b0);
        random_phase(220);
        drain();

        set_origins(-900000000, -1800000000);
        offer_fix(27'd90000000, 1'b0, 28'd180000000, 1'b1);
        offer_fix(27'd90000000, 1'b1, 28'd180000000, 1'b0);
        random_phase(220);
        drain();

        // A mid-latitude origin and then a random one.
        set_origins(473977420, 85455940);
        random_phase(220);
        drain();

        set_origins($urandom_range(0, 1800000000) - 900000000,
                    $urandom_range(0, 32'd3600000000) - 32'd1800000000);
        random_phase(150);

        // Last stretch: no idling on either side.
        calm = 1'b1;
        random_phase(140);
        in_valid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d fixes over %0d origin writes, %0d words checked.",
                 fixes_sent, origins_set, board.checked);
        $display("Origins included both corners of the globe, clamped and malformed fixes.");
        if (board.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("Timed out with %0d words still awaited.", board.awaited.size());
        $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gfo_pkg.sv
rtl/gfo_sincos.sv
rtl/gfo_dist.sv
rtl/gps_fix_to_local_offset_top.sv
rtl/gfo_chk.sv
dv/tb_top.sv
